>>> design/ipid_pkg.sv
// shared types, widths and register codes for the incremental pid speed loop
`timescale 1ns / 1ps

package ipid_pkg;

  localparam int SPD_W   = 16;
  localparam int TIME_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 24;
  localparam int ERR_W   = 17;
  localparam int D1_W    = 18;
  localparam int D2_W    = 19;
  localparam int PKP_W   = 35;
  localparam int PKI_W   = 34;
  localparam int PKD_W   = 36;
  localparam int INC_W   = 38;
  localparam int SUM_W   = 39;
  localparam int FRAC_W  = 8;
  localparam int CMP_W   = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [GAIN_W-1:0]  RST_RUN_KP   = 16'd15360;
  localparam logic [GAIN_W-1:0]  RST_RUN_KI   = 16'd512;
  localparam logic [GAIN_W-1:0]  RST_RUN_KD   = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_START_KP = 16'd5120;
  localparam logic [GAIN_W-1:0]  RST_START_KI = 16'd640;
  localparam logic [GAIN_W-1:0]  RST_START_KD = 16'd384;
  localparam logic [LIMIT_W-1:0] RST_LIMIT    = 15'd1000;

  typedef enum logic [2:0] {
    REG_RUN_KP   = 3'd0,
    REG_RUN_KI   = 3'd1,
    REG_RUN_KD   = 3'd2,
    REG_START_KP = 3'd3,
    REG_START_KI = 3'd4,
    REG_START_KD = 3'd5,
    REG_LIMIT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_set_t;

  typedef struct packed {
    gain_set_t          run;
    gain_set_t          start;
    logic [LIMIT_W-1:0] limit;
  } cfg_regs_t;

endpackage

>>> design/ipid_core.sv
// five-stage pid datapath: input, error differences, products, increment, clamped accumulate
`timescale 1ns / 1ps

module ipid_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ipid_pkg::cfg_regs_t                  cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ipid_pkg::SPD_W-1:0]    in_measured_speed,
  input  logic signed [ipid_pkg::SPD_W-1:0]    in_target_speed,
  input  logic        [ipid_pkg::TIME_W-1:0]   in_elapsed_time,
  input  logic        [ipid_pkg::TIME_W-1:0]   in_base_period,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ipid_pkg::DRIVE_W-1:0]  out_drive_value
);
  import ipid_pkg::*;

  // stage valid bits and per-stage free flags
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic free1, free2, free3, free4, free5;

  // stage 1: input register
  logic signed [SPD_W-1:0]  meas_s1_r, targ_s1_r;
  logic        [TIME_W-1:0] elap_s1_r, base_s1_r;

  // stage 2: errors and selected gains
  logic signed [ERR_W-1:0]  e0_s2_r;
  logic signed [D1_W-1:0]   d1_s2_r;
  logic signed [D2_W-1:0]   d2_s2_r;
  gain_set_t                gains_s2_r;
  logic signed [ERR_W-1:0]  e1_r, e2_r;

  // stage 3: products
  logic signed [PKP_W-1:0]  pkp_s3_r;
  logic signed [PKI_W-1:0]  pki_s3_r;
  logic signed [PKD_W-1:0]  pkd_s3_r;

  // stage 4: increment
  logic signed [INC_W-1:0]  inc_s4_r;

  // stage 5: accumulated drive, also the result register
  logic signed [DRIVE_W-1:0] accum_r;

  logic signed [ERR_W-1:0]  e0_c;
  logic signed [D1_W-1:0]   d1_c;
  logic signed [D2_W-1:0]   d2_c;
  logic        [CMP_W-1:0]  tenx_c, threex_c;
  logic                     startup_c;
  gain_set_t                gains_c;
  logic signed [GAIN_W:0]   kp_c, ki_c, kd_c;
  logic signed [PKP_W-1:0]  pkp_c;
  logic signed [PKI_W-1:0]  pki_c;
  logic signed [PKD_W-1:0]  pkd_c;
  logic signed [INC_W-1:0]  inc_c;
  logic signed [SUM_W-1:0]  sum_c, bound_c, nbound_c, clamp_c;

  assign free5    = !v5_r || out_ready;
  assign free4    = !v4_r || free5;
  assign free3    = !v3_r || free4;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign in_ready = free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
      if (free5) v5_r <= v4_r;
    end
  end

  // error history and drive accumulator are loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r    <= '0;
      e2_r    <= '0;
      accum_r <= '0;
    end else begin
      if (free2 && v1_r) begin
        e2_r <= e1_r;
        e1_r <= e0_c;
      end
      if (free5 && v4_r) accum_r <= clamp_c[DRIVE_W-1:0];
    end
  end

  // stage 2 logic
  assign e0_c = {targ_s1_r[SPD_W-1], targ_s1_r} - {meas_s1_r[SPD_W-1], meas_s1_r};
  assign d1_c = {e0_c[ERR_W-1], e0_c} - {e1_r[ERR_W-1], e1_r};
  assign d2_c = {{2{e0_c[ERR_W-1]}}, e0_c} - {e1_r[ERR_W-1], e1_r, 1'b0}
              + {{2{e2_r[ERR_W-1]}}, e2_r};

  // 10*elapsed <= 3*base picks the start-up gains
  assign tenx_c    = {1'b0, elap_s1_r, 3'b000} + {3'b000, elap_s1_r, 1'b0};
  assign threex_c  = {3'b000, base_s1_r, 1'b0} + {4'b0000, base_s1_r};
  assign startup_c = (tenx_c <= threex_c);
  assign gains_c   = startup_c ? cfg.start : cfg.run;

  // stage 3 logic
  assign kp_c  = {1'b0, gains_s2_r.kp};
  assign ki_c  = {1'b0, gains_s2_r.ki};
  assign kd_c  = {1'b0, gains_s2_r.kd};
  assign pkp_c = kp_c * d1_s2_r;
  assign pki_c = ki_c * e0_s2_r;
  assign pkd_c = kd_c * d2_s2_r;

  // stage 4 logic
  assign inc_c = {{(INC_W-PKP_W){pkp_s3_r[PKP_W-1]}}, pkp_s3_r}
               + {{(INC_W-PKI_W){pki_s3_r[PKI_W-1]}}, pki_s3_r}
               + {{(INC_W-PKD_W){pkd_s3_r[PKD_W-1]}}, pkd_s3_r};

  // stage 5 logic: accumulate then clamp to +/- limit in q16.8
  assign sum_c    = {{(SUM_W-DRIVE_W){accum_r[DRIVE_W-1]}}, accum_r}
                  + {{(SUM_W-INC_W){inc_s4_r[INC_W-1]}}, inc_s4_r};
  assign bound_c  = {{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, cfg.limit, {FRAC_W{1'b0}}};
  assign nbound_c = -bound_c;

  always_comb begin
    if (sum_c >= bound_c) begin
      clamp_c = bound_c;
    end else if (sum_c <= nbound_c) begin
      clamp_c = nbound_c;
    end else begin
      clamp_c = sum_c;
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && in_valid) begin
      meas_s1_r <= in_measured_speed;
      targ_s1_r <= in_target_speed;
      elap_s1_r <= in_elapsed_time;
      base_s1_r <= in_base_period;
    end
    if (free2 && v1_r) begin
      e0_s2_r    <= e0_c;
      d1_s2_r    <= d1_c;
      d2_s2_r    <= d2_c;
      gains_s2_r <= gains_c;
    end
    if (free3 && v2_r) begin
      pkp_s3_r <= pkp_c;
      pki_s3_r <= pki_c;
      pkd_s3_r <= pkd_c;
    end
    if (free4 && v3_r) inc_s4_r <= inc_c;
  end

  assign out_valid       = v5_r;
  assign out_drive_value = accum_r;

endmodule

>>> design/incremental_pid_speed_loop_top.sv
// top level: apb register file and the pid datapath
//
//   channel  direction  handshake        payload
//   in       input      in_valid/ready   measured_speed, target_speed, elapsed_time, base_period
//   out      output     out_valid/ready  drive_value (q16.8)
//   cfg      apb write  psel/penable     gains q8.8 and drive limit, byte address 4*index
//
// one item per cycle while out_ready keeps the result draining; an accepted item passes the input,
// error difference, multiplier and increment registers before the result register loads (five
// register stages: input, error differences, multipliers, increment sum, accumulate/clamp)
// rst_n is synchronous: clears the error history, the drive accumulator and all stage
// valid bits, and loads the default gains and limit
// a stalled result holds only the stages that are full behind it; empty stages keep filling
`timescale 1ns / 1ps

module incremental_pid_speed_loop_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ipid_pkg::SPD_W-1:0]    in_measured_speed,
  input  logic signed [ipid_pkg::SPD_W-1:0]    in_target_speed,
  input  logic        [ipid_pkg::TIME_W-1:0]   in_elapsed_time,
  input  logic        [ipid_pkg::TIME_W-1:0]   in_base_period,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ipid_pkg::DRIVE_W-1:0]  out_drive_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [ipid_pkg::ADDR_W-1:0]   paddr,
  input  logic        [ipid_pkg::DATA_W-1:0]   pwdata,
  output logic        [ipid_pkg::DATA_W-1:0]   prdata,
  output logic                                 pready
);
  import ipid_pkg::*;

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.run.kp   <= RST_RUN_KP;
      regs_r.run.ki   <= RST_RUN_KI;
      regs_r.run.kd   <= RST_RUN_KD;
      regs_r.start.kp <= RST_START_KP;
      regs_r.start.ki <= RST_START_KI;
      regs_r.start.kd <= RST_START_KD;
      regs_r.limit    <= RST_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_RUN_KP:   regs_r.run.kp   <= pwdata[GAIN_W-1:0];
        REG_RUN_KI:   regs_r.run.ki   <= pwdata[GAIN_W-1:0];
        REG_RUN_KD:   regs_r.run.kd   <= pwdata[GAIN_W-1:0];
        REG_START_KP: regs_r.start.kp <= pwdata[GAIN_W-1:0];
        REG_START_KI: regs_r.start.ki <= pwdata[GAIN_W-1:0];
        REG_START_KD: regs_r.start.kd <= pwdata[GAIN_W-1:0];
        REG_LIMIT:    regs_r.limit    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RUN_KP:   prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.run.kp};
      REG_RUN_KI:   prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.run.ki};
      REG_RUN_KD:   prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.run.kd};
      REG_START_KP: prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.start.kp};
      REG_START_KI: prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.start.ki};
      REG_START_KD: prdata = {{(DATA_W-GAIN_W){1'b0}}, regs_r.start.kd};
      REG_LIMIT:    prdata = {{(DATA_W-LIMIT_W){1'b0}}, regs_r.limit};
      default:      prdata = '0;
    endcase
  end

  ipid_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (regs_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_speed (in_measured_speed),
    .in_target_speed   (in_target_speed),
    .in_elapsed_time   (in_elapsed_time),
    .in_base_period    (in_base_period),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_value   (out_drive_value)
  );

endmodule

>>> design/ipid_checker.sv
// port-level checks for the pid speed loop, bound to the top level
`timescale 1ns / 1ps

module ipid_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ipid_pkg::DRIVE_W-1:0]  out_drive_value,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic                                 pready,
  input logic        [ipid_pkg::ADDR_W-1:0]   paddr,
  input logic        [ipid_pkg::DATA_W-1:0]   pwdata
);
  import ipid_pkg::*;

  // shadow copy of the drive limit seen on the bus
  logic [LIMIT_W-1:0]       lim_r;
  logic signed [DRIVE_W:0]  bnd;
  logic signed [DRIVE_W:0]  outx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= RST_LIMIT;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx_t'(paddr[ADDR_W-1:2]) == REG_LIMIT)) begin
      lim_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign bnd  = {2'b00, lim_r, {FRAC_W{1'b0}}};
  assign outx = {out_drive_value[DRIVE_W-1], out_drive_value};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_value))
    else $error("result changed while stalled");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (outx <= bnd) && (outx >= -bnd))
    else $error("drive value outside the limit");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the pipeline can drain");

endmodule

bind incremental_pid_speed_loop_top ipid_checker u_ipid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_drive_value (out_drive_value),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .paddr           (paddr),
  .pwdata          (pwdata)
);
